// ===== rtl/rc4_pkg.sv =====
package rc4_pkg;

    // Size of the permutation table; the cipher is defined for bytes only.
    localparam int PERM_DEPTH = 256;
    localparam int PERM_AW    = 8;

    // Default depth of the key store.
    localparam int KEY_STORE_DEPTH = 256;

    // Request kinds.
    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_in;
        logic       last_of_run;
    } req_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       last_out;
        logic       unkeyed;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_J,
        ST_RD_T,
        ST_OUT,
        ST_INIT,
        ST_KS_RD_S,
        ST_KS_RD_J,
        ST_KS_WR_N,
        ST_KS_WR_J
    } state_t;

endpackage

// ===== rtl/rc4_stream_cipher.sv =====
// RC4 stream cipher engine.
// Requests arrive on req (valid/ready). A key request stores one key byte while
// the key store has room; the key request marked last starts the key schedule
// and produces no response. A data request returns one response on rsp
// (valid/ready) holding the byte XORed with the next keystream byte; a data
// request marked last ends the message and returns both indices to zero while
// the permutation table keeps its contents. Data seen before any key completes
// passes through unchanged with unkeyed set.
// A keyed data byte goes through the states RD_J, RD_T and OUT, and the engine
// takes no new request until it is back in IDLE: reads of S[i], S[j] and S[t]
// plus the swap writes share the single read and write ports of the permutation
// RAM. An unkeyed byte goes from IDLE straight to OUT and back to IDLE. The key
// schedule fills the table in INIT and then makes 256 swap steps, each through
// KS_RD_S, KS_RD_J, KS_WR_N and KS_WR_J; no request is accepted meanwhile.
// The response sits in an output register: a request can be accepted while it
// waits; when the receiver stalls, the next finished byte waits in the engine.
// Reset clears the indices, the key count and the keyed flag; the RAM contents
// are not cleared and are written by the schedule before they are read.
module rc4_stream_cipher #(
    parameter int KEY_STORE_DEPTH = rc4_pkg::KEY_STORE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  rc4_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rc4_pkg::rsp_t rsp
);

    localparam int KAW = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1;
    localparam int KCW = $clog2(KEY_STORE_DEPTH + 1);
    localparam int PAW = rc4_pkg::PERM_AW;

    rc4_pkg::state_t state_reg, state_next;

    logic [PAW-1:0] i_reg, i_next;
    logic [PAW-1:0] j_reg, j_next;
    logic [PAW-1:0] n_reg, n_next;
    logic [PAW-1:0] t_reg, t_next;
    logic [7:0]     si_reg, si_next;
    logic [7:0]     sj_reg, sj_next;
    logic [7:0]     byte_reg, byte_next;
    logic           last_reg, last_next;
    logic           pass_reg, pass_next;
    logic           keyed_reg, keyed_next;
    logic [KCW-1:0] key_count_reg, key_count_next;
    logic [KAW-1:0] kidx_reg, kidx_next;
    logic           rsp_valid_reg, rsp_valid_next;
    rc4_pkg::rsp_t  rsp_reg, rsp_next;

    logic           perm_we;
    logic [PAW-1:0] perm_waddr, perm_raddr;
    logic [7:0]     perm_wdata, perm_rdata;
    logic           key_we;
    logic [7:0]     key_rdata;
    logic           req_accept;
    logic           out_free;
    logic [7:0]     ks_byte;
    logic [PAW-1:0] ks_j;

    // Permutation table and key store.
    rc4_ram #(
        .WIDTH (8),
        .DEPTH (rc4_pkg::PERM_DEPTH),
        .AW    (PAW)
    ) u_perm_ram (
        .clk   (clk),
        .we    (perm_we),
        .waddr (perm_waddr),
        .wdata (perm_wdata),
        .raddr (perm_raddr),
        .rdata (perm_rdata)
    );

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (KEY_STORE_DEPTH),
        .AW    (KAW)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_count_reg[KAW-1:0]),
        .wdata (req.byte_in),
        .raddr (kidx_reg),
        .rdata (key_rdata)
    );

    assign req_ready  = (state_reg == rc4_pkg::ST_IDLE);
    assign req_accept = req_valid && req_ready;
    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign key_we     = req_accept && (req.kind == rc4_pkg::KIND_KEY) &&
                        (key_count_reg < KCW'(KEY_STORE_DEPTH));
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    // Keystream byte S[t], with the swap writes forwarded over the raw read.
    always_comb
    begin
        if (t_reg == j_reg)
        begin
            ks_byte = si_reg;
        end
        else if (t_reg == i_reg)
        begin
            ks_byte = sj_reg;
        end
        else
        begin
            ks_byte = perm_rdata;
        end
    end

    // Schedule index j + S[n] + key byte.
    assign ks_j = j_reg + perm_rdata + key_rdata;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rc4_pkg::ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            keyed_reg     <= 1'b0;
            key_count_reg <= '0;
            kidx_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            keyed_reg     <= keyed_next;
            key_count_reg <= key_count_next;
            kidx_reg      <= kidx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        si_reg   <= si_next;
        sj_reg   <= sj_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        pass_reg <= pass_next;
        rsp_reg  <= rsp_next;
    end

    // Sequencer: next state, RAM accesses and register updates.
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        t_next         = t_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        pass_next      = pass_reg;
        keyed_next     = keyed_reg;
        key_count_next = key_count_reg;
        kidx_next      = kidx_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        perm_we        = 1'b0;
        perm_waddr     = n_reg;
        perm_wdata     = n_reg;
        perm_raddr     = n_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            rc4_pkg::ST_IDLE:
            begin
                // Read S[i+1] ahead so it is ready if a keyed data request arrives.
                perm_raddr = i_reg + 1'b1;
                if (req_accept)
                begin
                    byte_next = req.byte_in;
                    last_next = req.last_of_run;
                    if (req.kind == rc4_pkg::KIND_KEY)
                    begin
                        if (key_we)
                        begin
                            key_count_next = key_count_reg + 1'b1;
                        end
                        if (req.last_of_run)
                        begin
                            n_next     = '0;
                            kidx_next  = '0;
                            state_next = rc4_pkg::ST_INIT;
                        end
                    end
                    else if (keyed_reg)
                    begin
                        pass_next  = 1'b0;
                        state_next = rc4_pkg::ST_RD_J;
                    end
                    else
                    begin
                        pass_next  = 1'b1;
                        state_next = rc4_pkg::ST_OUT;
                    end
                end
            end

            rc4_pkg::ST_RD_J:
            begin
                // S[i] is out of the RAM; step j and read S[j].
                si_next    = perm_rdata;
                i_next     = i_reg + 1'b1;
                j_next     = j_reg + perm_rdata;
                perm_raddr = j_reg + perm_rdata;
                state_next = rc4_pkg::ST_RD_T;
            end

            rc4_pkg::ST_RD_T:
            begin
                // S[j] is out; write S[i] = S[j] and read S[t].
                sj_next    = perm_rdata;
                t_next     = perm_rdata + si_reg;
                perm_raddr = perm_rdata + si_reg;
                perm_we    = 1'b1;
                perm_waddr = i_reg;
                perm_wdata = perm_rdata;
                state_next = rc4_pkg::ST_OUT;
            end

            rc4_pkg::ST_OUT:
            begin
                // Hold the S[t] read until the output register is free.
                perm_raddr = t_reg;
                if (out_free)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_next.last_out = last_reg;
                    rsp_next.unkeyed  = pass_reg;
                    if (pass_reg)
                    begin
                        rsp_next.byte_out = byte_reg;
                    end
                    else
                    begin
                        rsp_next.byte_out = byte_reg ^ ks_byte;
                        perm_we           = 1'b1;
                        perm_waddr        = j_reg;
                        perm_wdata        = si_reg;
                        if (last_reg)
                        begin
                            i_next = '0;
                            j_next = '0;
                        end
                    end
                    state_next = rc4_pkg::ST_IDLE;
                end
            end

            rc4_pkg::ST_INIT:
            begin
                // Identity fill of the permutation table.
                perm_we = 1'b1;
                n_next  = n_reg + 1'b1;
                if (n_reg == '1)
                begin
                    j_next     = '0;
                    state_next = rc4_pkg::ST_KS_RD_S;
                end
            end

            rc4_pkg::ST_KS_RD_S:
            begin
                // Read S[n]; the key RAM reads the current key byte meanwhile.
                perm_raddr = n_reg;
                state_next = rc4_pkg::ST_KS_RD_J;
            end

            rc4_pkg::ST_KS_RD_J:
            begin
                si_next    = perm_rdata;
                j_next     = ks_j;
                perm_raddr = ks_j;
                state_next = rc4_pkg::ST_KS_WR_N;
            end

            rc4_pkg::ST_KS_WR_N:
            begin
                perm_we    = 1'b1;
                perm_waddr = n_reg;
                perm_wdata = perm_rdata;
                state_next = rc4_pkg::ST_KS_WR_J;
            end

            rc4_pkg::ST_KS_WR_J:
            begin
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = si_reg;
                n_next     = n_reg + 1'b1;
                // The key index cycles over the stored bytes.
                if ((KCW'(kidx_reg) + KCW'(1)) == key_count_reg)
                begin
                    kidx_next = '0;
                end
                else
                begin
                    kidx_next = kidx_reg + 1'b1;
                end
                if (n_reg == '1)
                begin
                    i_next         = '0;
                    j_next         = '0;
                    key_count_next = '0;
                    kidx_next      = '0;
                    keyed_next     = 1'b1;
                    state_next     = rc4_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = rc4_pkg::ST_KS_RD_S;
                end
            end

            default:
            begin
                state_next = rc4_pkg::ST_IDLE;
            end
        endcase
    end

    // A keyed data request always enters the read sequence.
    a_keyed_data_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && (req.kind == rc4_pkg::KIND_DATA) && keyed_reg)
        |=> (state_reg == rc4_pkg::ST_RD_J))
    else $error("keyed data request did not start the read sequence");

    // Once a key schedule has completed the engine stays keyed.
    a_keyed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(keyed_reg))
    else $error("keyed flag dropped");

    // A completed schedule leaves both indices and the key count at zero.
    a_schedule_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == rc4_pkg::ST_KS_WR_J) && (n_reg == '1))
        |=> ((i_reg == '0) && (j_reg == '0) && (key_count_reg == '0) && keyed_reg))
    else $error("schedule did not finish cleanly");

    // The key count never exceeds the store depth.
    a_key_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg <= KCW'(KEY_STORE_DEPTH))
    else $error("key count beyond store depth");

endmodule

// ===== rtl/rc4_ram.sv =====
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
